[sv/cfr_pkg.sv]
// Shared types and constants of the frame drop/duplicate scheduler.
package cfr_pkg;

	localparam int unsigned WORD_W = 64;

	localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_ARG   = 3'd1,
		ST_BAD_STATE = 3'd2,
		ST_BAD_TICK  = 3'd3,
		ST_NO_FRAME  = 3'd4,
		ST_FAILED    = 3'd5
	} status_t;

	typedef struct packed {
		logic                     kind;
		logic [WORD_W-1:0]        frame_sequence;
		logic signed [WORD_W-1:0] frame_timestamp_us;
		logic [WORD_W-1:0]        frame_surface;
		logic [WORD_W-1:0]        tick_number;
	} in_word_t;

	typedef struct packed {
		logic [2:0]               status;
		logic [WORD_W-1:0]        out_tick;
		logic [WORD_W-1:0]        out_sequence;
		logic signed [WORD_W-1:0] out_timestamp_us;
		logic [WORD_W-1:0]        out_surface;
		logic [WORD_W-1:0]        dropped_before;
		logic                     is_duplicate;
		logic [WORD_W-1:0]        source_total;
		logic [WORD_W-1:0]        output_total;
		logic [WORD_W-1:0]        dropped_total;
		logic [WORD_W-1:0]        duplicated_total;
	} out_word_t;

endpackage

[sv/cfr_if.sv]
// Valid/ready channel interfaces for input and result words.
interface cfr_in_if;
	logic              valid;
	logic              ready;
	cfr_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cfr_out_if;
	logic               valid;
	logic               ready;
	cfr_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/cfr_sched_core.sv]
// Scheduler state and the per-word decision logic for pushes and ticks.
module cfr_sched_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  cfr_pkg::in_word_t  word,
	output cfr_pkg::out_word_t res
);

	localparam int unsigned W = cfr_pkg::WORD_W;

	// Scheduler state.
	logic                seen_source_q;
	logic [W-1:0]        prev_src_sequence_q;
	logic signed [W-1:0] prev_src_timestamp_q;
	logic                pending_valid_q;
	logic [W-1:0]        pending_sequence_q;
	logic signed [W-1:0] pending_timestamp_q;
	logic [W-1:0]        pending_surface_q;
	logic                shown_valid_q;
	logic [W-1:0]        shown_sequence_q;
	logic signed [W-1:0] shown_timestamp_q;
	logic [W-1:0]        shown_surface_q;
	logic                seen_tick_q;
	logic [W-1:0]        prev_tick_q;
	logic [W-1:0]        dropped_pending_q;
	logic [W-1:0]        src_counter_q;
	logic [W-1:0]        out_counter_q;
	logic [W-1:0]        drop_counter_q;
	logic [W-1:0]        dup_counter_q;

	// Update strobes decided below.
	logic push_ok;
	logic push_drop;
	logic tick_rec;
	logic emit_fresh;
	logic emit_dup;
	logic push_bad;
	logic drop_full;
	logic tick_bad;
	cfr_pkg::status_t status;

	// Decide the outcome of the current word.
	always_comb begin
		push_bad = word.frame_timestamp_us[W-1]
			|| (seen_source_q && ((word.frame_sequence <= prev_src_sequence_q)
				|| (word.frame_timestamp_us < prev_src_timestamp_q)))
			|| (src_counter_q == cfr_pkg::ALL_ONES);
		drop_full = (drop_counter_q == cfr_pkg::ALL_ONES)
			|| (dropped_pending_q == cfr_pkg::ALL_ONES);
		tick_bad = seen_tick_q && (word.tick_number <= prev_tick_q);
		push_ok = 1'b0;
		push_drop = 1'b0;
		tick_rec = 1'b0;
		emit_fresh = 1'b0;
		emit_dup = 1'b0;
		status = cfr_pkg::ST_OK;
		if (word.kind == cfr_pkg::KIND_PUSH) begin
			if (push_bad) begin
				status = cfr_pkg::ST_BAD_ARG;
			end else if (pending_valid_q && drop_full) begin
				status = cfr_pkg::ST_BAD_STATE;
			end else begin
				push_ok = 1'b1;
				push_drop = pending_valid_q;
			end
		end else begin
			if (tick_bad) begin
				status = cfr_pkg::ST_BAD_TICK;
			end else begin
				tick_rec = 1'b1;
				if (!pending_valid_q && !shown_valid_q) begin
					status = cfr_pkg::ST_NO_FRAME;
				end else if (out_counter_q == cfr_pkg::ALL_ONES) begin
					status = cfr_pkg::ST_FAILED;
				end else if (pending_valid_q) begin
					emit_fresh = 1'b1;
				end else if (dup_counter_q == cfr_pkg::ALL_ONES) begin
					status = cfr_pkg::ST_FAILED;
				end else begin
					emit_dup = 1'b1;
				end
			end
		end
	end

	// Result word: frame fields only on an emitted frame, counters after update.
	always_comb begin
		res = '0;
		res.status = status;
		if (emit_fresh) begin
			res.out_tick = word.tick_number;
			res.out_sequence = pending_sequence_q;
			res.out_timestamp_us = pending_timestamp_q;
			res.out_surface = pending_surface_q;
			res.dropped_before = dropped_pending_q;
		end else if (emit_dup) begin
			res.out_tick = word.tick_number;
			res.out_sequence = shown_sequence_q;
			res.out_timestamp_us = shown_timestamp_q;
			res.out_surface = shown_surface_q;
			res.is_duplicate = 1'b1;
		end
		res.source_total = src_counter_q + W'(push_ok);
		res.output_total = out_counter_q + W'(emit_fresh || emit_dup);
		res.dropped_total = drop_counter_q + W'(push_drop);
		res.duplicated_total = dup_counter_q + W'(emit_dup);
	end

	// State update when the word is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_source_q <= 1'b0;
			prev_src_sequence_q <= '0;
			prev_src_timestamp_q <= '0;
			pending_valid_q <= 1'b0;
			pending_sequence_q <= '0;
			pending_timestamp_q <= '0;
			pending_surface_q <= '0;
			shown_valid_q <= 1'b0;
			shown_sequence_q <= '0;
			shown_timestamp_q <= '0;
			shown_surface_q <= '0;
			seen_tick_q <= 1'b0;
			prev_tick_q <= '0;
			dropped_pending_q <= '0;
			src_counter_q <= '0;
			out_counter_q <= '0;
			drop_counter_q <= '0;
			dup_counter_q <= '0;
		end else if (en) begin
			if (push_ok) begin
				pending_valid_q <= 1'b1;
				pending_sequence_q <= word.frame_sequence;
				pending_timestamp_q <= word.frame_timestamp_us;
				pending_surface_q <= word.frame_surface;
				seen_source_q <= 1'b1;
				prev_src_sequence_q <= word.frame_sequence;
				prev_src_timestamp_q <= word.frame_timestamp_us;
				src_counter_q <= res.source_total;
			end
			if (push_drop) begin
				drop_counter_q <= res.dropped_total;
				dropped_pending_q <= dropped_pending_q + W'(1);
			end
			if (tick_rec) begin
				seen_tick_q <= 1'b1;
				prev_tick_q <= word.tick_number;
			end
			if (emit_fresh) begin
				shown_valid_q <= 1'b1;
				shown_sequence_q <= pending_sequence_q;
				shown_timestamp_q <= pending_timestamp_q;
				shown_surface_q <= pending_surface_q;
				pending_valid_q <= 1'b0;
				dropped_pending_q <= '0;
			end
			if (emit_fresh || emit_dup) begin
				out_counter_q <= res.output_total;
			end
			if (emit_dup) begin
				dup_counter_q <= res.duplicated_total;
			end
		end
	end

endmodule

[sv/cfr_frame_drop_duplicate_scheduler_unit.sv]
// Frame drop/duplicate scheduler: one result word for each input word.
// An accepted word is held in the input register, then its result in the result register.
// Throughput: one word per cycle unless the result side stalls, set by the core's state update.
// Input ready follows result ready combinationally while both registers are full.
// Reset (arst_n low) clears all counters, the pending and shown frames and both pipeline valids.
module cfr_frame_drop_duplicate_scheduler_unit (
	input logic      clk,
	input logic      arst_n,
	cfr_in_if.sink   item,
	cfr_out_if.source result
);

	logic               valid_s1;
	cfr_pkg::in_word_t  word_s1;
	logic               res_valid_q;
	cfr_pkg::out_word_t res_q;
	cfr_pkg::out_word_t res_comb;
	logic               advance;

	// The registered word moves on when the result register is free or draining.
	assign advance = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			word_s1 <= item.data;
		end
	end

	cfr_sched_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.word   (word_s1),
		.res    (res_comb)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_comb;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data = res_q;

endmodule
